// ----- rtl/contact_manifold_insert_unit_defines.svh -----
// Assertion macros shared by the contact manifold insert unit.
`ifndef CONTACT_MANIFOLD_INSERT_UNIT_DEFINES_SVH
`define CONTACT_MANIFOLD_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CMI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cmi_pkg.sv -----
// Types and constants of the contact manifold insert unit.
`default_nettype none

package cmi_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Replacement only considers depths above -10000.0 in Q16.16.
  localparam logic signed [31:0] DEPTH_FLOOR = -32'sd655360000;

  typedef enum logic [2:0] {
    ACT_UPDATE  = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_DROP    = 3'd3,
    ACT_CLEAR   = 3'd4
  } cmi_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } cmi_state_e;

  typedef struct packed {
    logic               operation;
    logic        [31:0] feature_id;
    logic signed [31:0] depth;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] slot;
    logic [2:0] action;
    logic [2:0] filled;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } pos_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmi_cmd_t;

  typedef struct packed {
    logic skip;
    logic hit_now;
    logic last;
    logic out_free;
  } cmi_sts_t;

endpackage

`default_nettype wire

// ----- rtl/cmi_stream_if.sv -----
// Valid/ready channel interfaces for the request and result words.
`default_nettype none

interface cmi_cmd_if;
  logic               valid;
  logic               ready;
  cmi_pkg::in_word_t  word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface cmi_rsp_if;
  logic               valid;
  logic               ready;
  cmi_pkg::out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- rtl/cmi_ctrl.sv -----
// Controller state machine sequencing accept, table scan and commit.
`default_nettype none
`include "contact_manifold_insert_unit_defines.svh"

module cmi_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cmi_pkg::cmi_sts_t sts_i,
  output cmi_pkg::cmi_cmd_t      cmd_o
);

  cmi_pkg::cmi_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cmi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = cmi_pkg::ST_SCAN;
        end
      end
      cmi_pkg::ST_SCAN: begin
        if (sts_i.skip) begin
          state_d = cmi_pkg::ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.hit_now || sts_i.last) begin
            state_d = cmi_pkg::ST_DONE;
          end
        end
      end
      cmi_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = cmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmi_pkg::ST_IDLE;
      end
    endcase
  end

  `CMI_ASSERT_NXT(a_scan_ends, (state_q == cmi_pkg::ST_SCAN) && (sts_i.skip || sts_i.hit_now || sts_i.last), state_q == cmi_pkg::ST_DONE, "Scan did not finish at a match or the last entry.")
  `CMI_ASSERT_NXT(a_accept_scans, in_valid_i && in_ready_o, (state_q == cmi_pkg::ST_SCAN) && !in_ready_o, "Accepted word did not start a scan.")

endmodule

`default_nettype wire

// ----- rtl/cmi_datapath.sv -----
// Contact table, scan registers, decision logic and result register.
`default_nettype none
`include "contact_manifold_insert_unit_defines.svh"

module cmi_datapath #(
  parameter int TABLE_SIZE = 4,
  parameter int ID_BITS    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmi_pkg::cmi_cmd_t  cmd_i,
  output cmi_pkg::cmi_sts_t       sts_o,
  input  wire cmi_pkg::in_word_t  word_i,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_ready_i,
  output cmi_pkg::out_word_t      rsp_word_o
);

  localparam int IdxW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CntW = $clog2(TABLE_SIZE + 1);
  localparam int IdW  = (ID_BITS < 32) ? ID_BITS : 32;
  localparam logic [CntW-1:0] TableFull = CntW'(TABLE_SIZE);

  cmi_pkg::in_word_t    word_q;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      pick_q;
  logic signed [31:0]   best_q;
  logic                 hit_q;
  logic                 allow_q;
  logic [CntW-1:0]      count_q;
  logic                 rsp_valid_q;
  cmi_pkg::out_word_t   rsp_q;
  cmi_pkg::vec3_t       normal_q;

  logic [IdW-1:0]       feat_q  [TABLE_SIZE];
  logic signed [31:0]   depth_q [TABLE_SIZE];
  cmi_pkg::pos_t        pos_q   [TABLE_SIZE];

  logic [IdW-1:0]       id;
  logic [IdW-1:0]       cur_feat;
  logic signed [31:0]   cur_depth;
  logic                 hit_now;
  logic                 last;
  logic                 full;
  logic                 is_clear;
  logic                 wr_en;
  logic [IdxW-1:0]      widx;
  logic [CntW-1:0]      count_d;
  cmi_pkg::cmi_action_e action;
  logic [31:0]          widx_ext;
  logic [31:0]          count_ext;

  assign id        = word_q.feature_id[IdW-1:0];
  assign cur_feat  = feat_q[idx_q];
  assign cur_depth = depth_q[idx_q];
  assign hit_now   = (cur_feat == id);
  assign last      = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign full      = (count_q == TableFull);
  assign is_clear  = (word_q.operation == cmi_pkg::OP_CLEAR);

  assign sts_o.skip     = is_clear || (count_q == '0);
  assign sts_o.hit_now  = hit_now;
  assign sts_o.last     = last;
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    wr_en   = 1'b0;
    widx    = '0;
    count_d = count_q;
    action  = cmi_pkg::ACT_DROP;
    if (is_clear) begin
      action  = cmi_pkg::ACT_CLEAR;
      count_d = '0;
    end else if (hit_q) begin
      wr_en  = 1'b1;
      widx   = idx_q;
      action = cmi_pkg::ACT_UPDATE;
    end else if (!full) begin
      wr_en   = 1'b1;
      widx    = count_q[IdxW-1:0];
      action  = cmi_pkg::ACT_APPEND;
      count_d = count_q + CntW'(1);
    end else if (allow_q) begin
      wr_en  = 1'b1;
      widx   = pick_q;
      action = cmi_pkg::ACT_REPLACE;
    end
  end

  assign widx_ext  = 32'(widx);
  assign count_ext = 32'(count_d);

  // Scan registers: one table entry is examined per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      allow_q <= 1'b1;
    end else if (cmd_i.start) begin
      hit_q   <= 1'b0;
      allow_q <= 1'b1;
    end else if (cmd_i.step) begin
      if (hit_now) begin
        hit_q <= 1'b1;
      end else if (((cur_feat & id) == id) && (cur_feat > id)) begin
        allow_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      word_q <= word_i;
      idx_q  <= '0;
      pick_q <= '0;
      best_q <= cmi_pkg::DEPTH_FLOOR;
    end else if (cmd_i.step && !hit_now) begin
      if (cur_depth > best_q) begin
        best_q <= cur_depth;
        pick_q <= idx_q;
      end
      if (!last) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      feat_q[widx]  <= id;
      depth_q[widx] <= word_q.depth;
      pos_q[widx]   <= '{a_x: word_q.point_a_x, a_y: word_q.point_a_y,
                         a_z: word_q.point_a_z, b_x: word_q.point_b_x,
                         b_y: word_q.point_b_y, b_z: word_q.point_b_z};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      normal_q    <= '0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
        if (!is_clear && (count_q == '0)) begin
          normal_q <= '{x: word_q.normal_x, y: word_q.normal_y, z: word_q.normal_z};
        end
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.slot   <= widx_ext[1:0];
      rsp_q.action <= action;
      rsp_q.filled <= count_ext[2:0];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_word_o  = rsp_q;

  `CMI_ASSERT_IMP(a_count_bound, 1'b1, count_q <= TableFull, "Entry count exceeds the table size.")
  `CMI_ASSERT_NXT(a_commit_shows, cmd_i.commit, rsp_valid_q, "Committed result word is not presented.")
  `CMI_ASSERT_NXT(a_drop_keeps, cmd_i.commit && (action == cmi_pkg::ACT_DROP), $stable(count_q), "A dropped point changed the entry count.")

endmodule

`default_nettype wire

// ----- rtl/contact_manifold_insert_unit.sv -----
// A word is accepted in the idle state, then the table is scanned one entry per cycle
// (skipped when the table is empty or the word is a clear), and the result is then committed
// once the output register is free; one item is in work at a time.
// A finished result waits in an output register while the next word is taken.
// Reset empties the table and the output; entry contents are undefined until written.
`default_nettype none

module contact_manifold_insert_unit #(
  parameter int TABLE_SIZE = 4,
  parameter int ID_BITS    = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cmi_cmd_if.sink    cmd_i,
  cmi_rsp_if.source  rsp_o
);

  cmi_pkg::cmi_cmd_t  cmd;
  cmi_pkg::cmi_sts_t  sts;
  logic               in_ready;
  logic               rsp_valid;
  cmi_pkg::out_word_t rsp_word;

  cmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmi_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .word_i      (cmd_i.word),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_word_o  (rsp_word)
  );

  assign cmd_i.ready = in_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.word  = rsp_word;

endmodule

`default_nettype wire

// ----- sim/tb_contact_manifold_insert_unit.sv -----
// Self-checking testbench of the contact manifold insert unit against its own cache predictor.
`timescale 1ns / 100ps

module tb_contact_manifold_insert_unit;

  localparam int SLOTS        = 4;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int RANDOM_WORDS = 1530;

  logic clk_i = 1'b0;
  logic rst_ni;

  cmi_cmd_if cmd_if ();
  cmi_rsp_if rsp_if ();

  contact_manifold_insert_unit #(
    .TABLE_SIZE(SLOTS),
    .ID_BITS   (32)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  cmi_pkg::in_word_t  pending_words[$];
  cmi_pkg::out_word_t expected_results[$];
  logic [31:0]        recent_ids[$];
  int                 total_words  = 0;
  int                 words_taken  = 0;
  int                 results_seen = 0;
  int                 mismatches   = 0;
  int                 stall_left   = 0;
  bit                 stall_done   = 1'b0;

  logic [31:0]        cache_id[SLOTS];
  logic signed [31:0] cache_depth[SLOTS];
  cmi_pkg::pos_t      cache_pos[SLOTS];
  cmi_pkg::vec3_t     cache_normal = '0;
  int unsigned        cache_count  = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic cmi_pkg::out_word_t apply_to_cache(input cmi_pkg::in_word_t w);
    cmi_pkg::out_word_t r;
    int unsigned        idx;
    int unsigned        pick;
    logic [SLOT_W-1:0]  sel;
    logic signed [31:0] best;
    bit                 allow;
    bit                 hit;
    r = '0;
    if (w.operation == cmi_pkg::OP_CLEAR) begin
      cache_count = 0;
      r.action = cmi_pkg::ACT_CLEAR;
      return r;
    end
    pick  = 0;
    best  = cmi_pkg::DEPTH_FLOOR;
    allow = 1'b1;
    hit   = 1'b0;
    for (idx = 0; idx < cache_count; idx++) begin
      sel = SLOT_W'(idx);
      if (cache_id[sel] == w.feature_id) begin
        hit = 1'b1;
        break;
      end
      if (cache_depth[sel] > best) begin
        best = cache_depth[sel];
        pick = idx;
      end
      if ((cache_id[sel] & w.feature_id) == w.feature_id && cache_id[sel] > w.feature_id)
        allow = 1'b0;
    end
    if (cache_count == 0)
      cache_normal = {w.normal_x, w.normal_y, w.normal_z};
    if (hit) begin
      r.action = cmi_pkg::ACT_UPDATE;
    end else if (idx < SLOTS) begin
      r.action = cmi_pkg::ACT_APPEND;
    end else if (!allow) begin
      r.action = cmi_pkg::ACT_DROP;
      r.filled = 3'(cache_count);
      return r;
    end else begin
      idx = pick;
      r.action = cmi_pkg::ACT_REPLACE;
    end
    sel = SLOT_W'(idx);
    cache_id[sel]    = w.feature_id;
    cache_depth[sel] = w.depth;
    cache_pos[sel]   = {w.point_a_x, w.point_a_y, w.point_a_z,
                        w.point_b_x, w.point_b_y, w.point_b_z};
    if (idx == cache_count)
      cache_count = idx + 1;
    r.slot   = 2'(idx);
    r.filled = 3'(cache_count);
    return r;
  endfunction

  function automatic cmi_pkg::in_word_t contact_word(input logic [31:0] id,
                                                     input logic signed [31:0] depth);
    cmi_pkg::in_word_t w;
    w.operation  = cmi_pkg::OP_INSERT;
    w.feature_id = id;
    w.depth      = depth;
    w.point_a_x  = $urandom();
    w.point_a_y  = $urandom();
    w.point_a_z  = $urandom();
    w.point_b_x  = $urandom();
    w.point_b_y  = $urandom();
    w.point_b_z  = $urandom();
    w.normal_x   = $urandom();
    w.normal_y   = $urandom();
    w.normal_z   = $urandom();
    return w;
  endfunction

  function automatic cmi_pkg::in_word_t clear_word();
    cmi_pkg::in_word_t w;
    w = contact_word($urandom(), $urandom());
    w.operation = cmi_pkg::OP_CLEAR;
    return w;
  endfunction

  function automatic logic signed [31:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return cmi_pkg::DEPTH_FLOOR;
      1:       return cmi_pkg::DEPTH_FLOOR + $signed($urandom_range(0, 4)) - 2;
      2:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      3, 4:    return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Small ids and near relatives of recent ones make matches and superset vetoes common.
  function automatic logic [31:0] pick_feature();
    logic [31:0] base;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (recent_ids.size() != 0)
      base = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    else
      base = $urandom_range(1, 15);
    if (roll < 35) return base;
    if (roll < 45) return base | (32'd1 << $urandom_range(0, 7));
    if (roll < 55) return base & $urandom();
    if (roll < 85) return $urandom_range(0, 255);
    return $urandom();
  endfunction

  function automatic int idle_percent(input int done);
    return (done >= 800 && done < 1100) ? 0 : 10;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.word  <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_results.push_back(apply_to_cache(cmd_if.word));
        words_taken <= words_taken + 1;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_percent(words_taken)) begin
          cmd_if.valid <= 1'b1;
          cmd_if.word  <= pending_words.pop_front();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cmi_pkg::out_word_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: slot %0d action %0d filled %0d",
                                    rsp_if.word.slot, rsp_if.word.action, rsp_if.word.filled));
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.word.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, wanted %0d", rsp_if.word.slot, want.slot));
          if (rsp_if.word.action !== want.action)
            report_mismatch($sformatf("action %0d, wanted %0d", rsp_if.word.action, want.action));
          if (rsp_if.word.filled !== want.filled)
            report_mismatch($sformatf("filled %0d, wanted %0d", rsp_if.word.filled, want.filled));
        end
      end
      rsp_if.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= idle_percent(results_seen));
    end
  end

  // One long hold-off on the result side, so that the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && results_seen >= 400) begin
      stall_left <= 300;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    logic [31:0] id;
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.word  = '0;
    rsp_if.ready = 1'b0;

    pending_words.push_back(clear_word());
    pending_words.push_back(contact_word(32'h0000_000f, 32'sd0));
    pending_words.push_back(contact_word(32'h0000_000f, 32'sh7fff_ffff));
    pending_words.push_back(contact_word(32'h0000_0003, cmi_pkg::DEPTH_FLOOR));
    pending_words.push_back(contact_word(32'h0000_0000, 32'sh8000_0000));
    pending_words.push_back(contact_word(32'h0000_0030, cmi_pkg::DEPTH_FLOOR + 1));
    pending_words.push_back(contact_word(32'h0000_0001, 32'sd5));
    pending_words.push_back(contact_word(32'h0000_0100, -32'sd5));
    pending_words.push_back(contact_word(32'h0000_0003, 32'sd100));
    pending_words.push_back(contact_word(32'h0000_0030, 32'sd100));
    pending_words.push_back(contact_word(32'h0000_0800, 32'sd9));
    pending_words.push_back(clear_word());
    pending_words.push_back(contact_word(32'h0000_0001, cmi_pkg::DEPTH_FLOOR));
    pending_words.push_back(contact_word(32'h0000_0002, 32'sh8000_0000));
    pending_words.push_back(contact_word(32'h0000_0004, cmi_pkg::DEPTH_FLOOR));
    pending_words.push_back(contact_word(32'h0000_0008, 32'sh8000_0001));
    pending_words.push_back(contact_word(32'h0000_0010, 32'sd0));
    pending_words.push_back(contact_word(32'hffff_ffff, 32'sh7fff_ffff));
    pending_words.push_back(contact_word(32'h0000_0000, 32'sd0));
    pending_words.push_back(contact_word(32'hffff_ffff, 32'sh8000_0000));
    pending_words.push_back(clear_word());

    repeat (RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 6) begin
        pending_words.push_back(clear_word());
      end else begin
        id = pick_feature();
        pending_words.push_back(contact_word(id, pick_depth()));
        recent_ids.push_back(id);
        if (recent_ids.size() > 8)
          void'(recent_ids.pop_front());
      end
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < total_words) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3 * SLOTS + 6) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cmi_pkg.sv
rtl/cmi_stream_if.sv
rtl/cmi_ctrl.sv
rtl/cmi_datapath.sv
rtl/contact_manifold_insert_unit.sv
sim/tb_contact_manifold_insert_unit.sv
